// ===== rtl/core/ils_pkg.sv =====
// Shared constants, codes and types of the indexed list store.
package ils_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 7;
  localparam int STATUS_W     = 2;
  localparam int CNT_OUT_W    = 7;
  localparam int CAPACITY_DEF = 64;

  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/ils_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
interface ils_in_if import ils_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

interface ils_out_if import ils_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     hit;
  logic [STATUS_W-1:0]      status;
  logic [CNT_OUT_W-1:0]     entry_count;

  modport source (output valid, output read_value, output hit, output status,
                  output entry_count, input ready);
  modport sink (input valid, input read_value, input hit, input status,
                input entry_count, output ready);
endinterface

// ===== rtl/core/indexed_list_store_core.sv =====
// Top level of the indexed list store: a row of list cells and the operation control.
// The list lives in a row of CAPACITY cells kept in list order; an insert shifts the cells at
// and above the position up by one, a delete shifts the cells above it down by one, and a read
// selects one cell onto a shared OR bus. One request transaction is accepted per clock while the
// response register is empty or being drained, and its response appears in the next cycle.
// Entries need no clearing after reset; count starts at zero.
module indexed_list_store_core import ils_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  ils_in_if.sink    req,
  ils_out_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     accept;
  logic [IW-1:0]            cnt_x;
  logic [IW-1:0]            pos_x;
  logic [IW-1:0]            ins_pos;
  logic [IW-1:0]            cell_pos;
  logic                     is_ins;
  logic [1:0]               mode;
  logic signed [DATA_W-1:0] rd;
  logic                     hit;
  logic [STATUS_W-1:0]      st;
  logic signed [DATA_W-1:0] sel_bus;
  cell_cmd_t                cmd;

  logic signed [DATA_W-1:0] entry_w [CAPACITY];
  logic signed [DATA_W-1:0] sel_w [CAPACITY];

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cnt_x     = IW'(count);
  assign pos_x     = IW'(req.position);

  always_comb begin
    rd         = '0;
    hit        = 1'b0;
    st         = ST_DONE;
    count_next = count;
    mode       = CELL_HOLD;
    is_ins     = 1'b0;
    ins_pos    = pos_x;
    case (req.operation)
      OP_READ: begin
        if (pos_x < cnt_x) begin
          hit = 1'b1;
          rd  = sel_bus;
        end else begin
          rd = '1;
        end
      end
      OP_INS_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      OP_INS_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt_x;
      end
      OP_INS_POS: begin
        is_ins  = 1'b1;
        ins_pos = pos_x;
      end
      OP_DELETE: begin
        if (pos_x < cnt_x) begin
          mode       = CELL_DEL;
          count_next = count - CW'(1);
        end else begin
          st = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    if (is_ins) begin
      if (ins_pos > cnt_x) begin
        st = ST_RANGE;
      end else if (count == CW'(CAPACITY)) begin
        st = ST_FULL;
      end else begin
        mode       = CELL_INS;
        count_next = count + CW'(1);
      end
    end
  end

  assign cell_pos  = is_ins ? ins_pos : pos_x;
  assign cmd.mode  = accept ? mode : CELL_HOLD;
  assign cmd.value = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry_w[i+1];
    end
    ils_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (cell_pos),
      .left      (left),
      .right     (right),
      .entry_out (entry_w[i]),
      .sel_data  (sel_w[i])
    );
  end

  always_comb begin
    sel_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_bus = sel_bus | sel_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value  <= rd;
      rsp.hit         <= hit;
      rsp.status      <= st;
      rsp.entry_count <= CNT_OUT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count changed without a transaction");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count) || count == $past(count) + CW'(1) ||
                count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_hit_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.hit |-> rsp.status == ST_DONE)
    else $error("read hit reported with a failure status");

endmodule

// ===== rtl/core/ils_cell.sv =====
// One list slot: holds an entry, loads the new value, or shifts from a neighbor.
module ils_cell import ils_pkg::*; #(
  parameter int IW    = POS_W,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [IW-1:0]            pos,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] entry_out,
  output logic signed [DATA_W-1:0] sel_data
);

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic signed [DATA_W-1:0] entry;

  always_ff @(posedge clk) begin
    case (cmd.mode)
      CELL_INS: begin
        if (IDX == pos) begin
          entry <= cmd.value;
        end else if (IDX > pos) begin
          entry <= left;
        end
      end
      CELL_DEL: begin
        if (IDX >= pos) begin
          entry <= right;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry_out = entry;
  assign sel_data  = (IDX == pos) ? entry : '0;

endmodule
